[design/clc_pkg.sv]
package clc_pkg;

	// node pool size and derived widths
	localparam int POOL_NODES = 16;
	localparam int NODE_W     = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
	localparam int CNT_W      = $clog2(POOL_NODES + 1);
	localparam int DATA_W     = 32;

	// request codes
	localparam logic [1:0] ACT_ADD     = 2'd0;
	localparam logic [1:0] ACT_REMOVE  = 2'd1;
	localparam logic [1:0] ACT_ADVANCE = 2'd2;

	// status codes
	localparam logic [1:0] STS_DONE  = 2'd0;
	localparam logic [1:0] STS_EMPTY = 2'd1;
	localparam logic [1:0] STS_FULL  = 2'd2;

endpackage

[design/circular_list_with_cursor_core.sv]
// Circular singly linked list with a cursor, kept in a node pool of
// clc_pkg::POOL_NODES entries. A request (start high while busy is low) adds
// a value after the cursor, removes the node after the cursor, or advances the
// cursor. Each request gives exactly one result: done goes high at the second
// clock edge after the request was taken and stays high for that one cycle,
// and the receiver must take it then. A new request may be taken in the same
// cycle that done is high, so the block handles one request every three
// cycles; that figure comes from the two dependent one-cycle memory reads (the
// link of the node after the cursor, then the element it points to) plus the
// idle cycle in which the result is shown. Removing or advancing an empty list
// reports status 1, an add with every node in use reports status 2, and both
// leave the list unchanged. No clearing pass is needed after reset.
module circular_list_with_cursor_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [1:0]                  action,
	input  logic signed [31:0]          value,
	output logic                        done,
	output logic                        is_empty,
	output logic signed [31:0]          front_value,
	output logic signed [31:0]          back_value,
	output logic [1:0]                  status
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_LINK = 2'd1;
	localparam logic [1:0] S_ELEM = 2'd2;

	// node memories and free stack
	logic [clc_pkg::DATA_W-1:0] elem_mem [clc_pkg::POOL_NODES];
	logic [clc_pkg::NODE_W-1:0] link_mem [clc_pkg::POOL_NODES];
	logic [clc_pkg::NODE_W-1:0] fs_mem   [clc_pkg::POOL_NODES];

	logic [1:0]                 state_q;
	logic [1:0]                 act_q;
	logic [clc_pkg::DATA_W-1:0] val_q;
	logic [clc_pkg::NODE_W-1:0] cur_q;
	logic [clc_pkg::NODE_W-1:0] next_q;
	logic                       occ_q;
	logic [clc_pkg::CNT_W-1:0]  nuc_q;
	logic [clc_pkg::CNT_W-1:0]  depth_q;
	logic [clc_pkg::DATA_W-1:0] front_q;
	logic [clc_pkg::DATA_W-1:0] back_q;
	logic [1:0]                 status_q;
	logic                       done_q;
	logic [clc_pkg::NODE_W-1:0] node_q;
	logic                       pend_link_q;
	logic                       pend_front_q;

	logic [clc_pkg::NODE_W-1:0] link_rdata_q;
	logic [clc_pkg::DATA_W-1:0] elem_rdata_q;
	logic [clc_pkg::NODE_W-1:0] fs_rdata_q;

	logic                       from_stack;
	logic                       pool_full;
	logic [clc_pkg::NODE_W-1:0] alloc_node;
	logic                       do_add;
	logic                       do_remove;
	logic                       do_advance;
	logic                       last_node;
	logic [clc_pkg::CNT_W-1:0]  depth_dec;

	logic                       link_we;
	logic [clc_pkg::NODE_W-1:0] link_waddr;
	logic [clc_pkg::NODE_W-1:0] link_wdata;

	// node allocation and request decode
	always_comb begin
		from_stack = (depth_q != '0);
		pool_full  = !from_stack && (nuc_q == clc_pkg::CNT_W'(clc_pkg::POOL_NODES));
		alloc_node = from_stack ? fs_rdata_q : nuc_q[clc_pkg::NODE_W-1:0];
		do_add     = (act_q == clc_pkg::ACT_ADD) && !pool_full;
		do_remove  = (act_q == clc_pkg::ACT_REMOVE) && occ_q;
		do_advance = (act_q == clc_pkg::ACT_ADVANCE) && occ_q;
		last_node  = (next_q == cur_q);
		depth_dec  = depth_q - clc_pkg::CNT_W'(1);
	end

	// single link write port: new node's link first, cursor's link after
	always_comb begin
		link_we    = 1'b0;
		link_waddr = cur_q;
		link_wdata = node_q;
		if (state_q == S_LINK) begin
			if (do_add) begin
				link_we    = 1'b1;
				link_waddr = alloc_node;
				link_wdata = occ_q ? next_q : alloc_node;
			end else if (do_remove && !last_node) begin
				link_we    = 1'b1;
				link_waddr = cur_q;
				link_wdata = link_rdata_q;
			end
		end else if (state_q == S_ELEM) begin
			link_we = pend_link_q;
		end
	end

	// link memory: read the node after the cursor while idle
	always_ff @(posedge clk) begin
		if (link_we) begin
			link_mem[link_waddr] <= link_wdata;
		end
		link_rdata_q <= link_mem[next_q];
	end

	// element memory: write on add, read the new front element
	always_ff @(posedge clk) begin
		if ((state_q == S_LINK) && do_add) begin
			elem_mem[alloc_node] <= val_q;
		end
		elem_rdata_q <= elem_mem[link_rdata_q];
	end

	// free stack: read the top while idle, push on remove
	always_ff @(posedge clk) begin
		if ((state_q == S_LINK) && do_remove
				&& (depth_q < clc_pkg::CNT_W'(clc_pkg::POOL_NODES))) begin
			fs_mem[depth_q[clc_pkg::NODE_W-1:0]] <= next_q;
		end
		fs_rdata_q <= fs_mem[depth_dec[clc_pkg::NODE_W-1:0]];
	end

	// request payload
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			act_q <= action;
			val_q <= value;
		end
		if (state_q == S_LINK) begin
			node_q <= alloc_node;
		end
	end

	// control sequence and list state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cur_q        <= '0;
			next_q       <= '0;
			occ_q        <= 1'b0;
			nuc_q        <= '0;
			depth_q      <= '0;
			front_q      <= '0;
			back_q       <= '0;
			status_q     <= clc_pkg::STS_DONE;
			done_q       <= 1'b0;
			pend_link_q  <= 1'b0;
			pend_front_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_LINK;
					end
				end
				S_LINK: begin
					state_q      <= S_ELEM;
					status_q     <= clc_pkg::STS_DONE;
					pend_link_q  <= 1'b0;
					pend_front_q <= 1'b0;
					if (act_q == clc_pkg::ACT_ADD) begin
						if (pool_full) begin
							status_q <= clc_pkg::STS_FULL;
						end else begin
							if (from_stack) begin
								depth_q <= depth_dec;
							end else begin
								nuc_q <= nuc_q + clc_pkg::CNT_W'(1);
							end
							next_q  <= alloc_node;
							front_q <= val_q;
							if (occ_q) begin
								pend_link_q <= 1'b1;
							end else begin
								cur_q  <= alloc_node;
								back_q <= val_q;
								occ_q  <= 1'b1;
							end
						end
					end else if (act_q inside {clc_pkg::ACT_REMOVE, clc_pkg::ACT_ADVANCE}) begin
						if (!occ_q) begin
							status_q <= clc_pkg::STS_EMPTY;
						end else begin
							if (do_remove) begin
								if (depth_q < clc_pkg::CNT_W'(clc_pkg::POOL_NODES)) begin
									depth_q <= depth_q + clc_pkg::CNT_W'(1);
								end
								if (last_node) begin
									occ_q <= 1'b0;
								end else begin
									next_q       <= link_rdata_q;
									pend_front_q <= 1'b1;
								end
							end else if (do_advance) begin
								cur_q        <= next_q;
								back_q       <= front_q;
								next_q       <= link_rdata_q;
								pend_front_q <= 1'b1;
							end
						end
					end
				end
				S_ELEM: begin
					state_q <= S_IDLE;
					done_q  <= 1'b1;
					if (pend_front_q) begin
						front_q <= elem_rdata_q;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// result ports
	assign busy        = (state_q != S_IDLE);
	assign done        = done_q;
	assign is_empty    = !occ_q;
	assign front_value = occ_q ? front_q : '0;
	assign back_value  = occ_q ? back_q : '0;
	assign status      = status_q;

`ifndef ASSERT_OFF
	// a result follows only the element read step
	a_done_after_elem: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q == S_ELEM))
		else $error("result without a finished request");

	// every node on the free stack was handed out before
	a_stack_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= nuc_q)
		else $error("free stack deeper than nodes ever used");

	// the result strobe lasts one cycle
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result strobe held");
`endif

endmodule

[bench/clc_list_checker.sv]
module clc_list_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                busy,
	input  logic [1:0]          action,
	input  logic signed [31:0]  value,
	input  logic                done,
	input  logic                is_empty,
	input  logic signed [31:0]  front_value,
	input  logic signed [31:0]  back_value,
	input  logic [1:0]          status,
	output int                  mismatch_count,
	output int                  results_owed
);

	timeunit 1ns;
	timeprecision 1ps;

	// what the list looks like after one request
	typedef struct packed {
		logic                              is_empty;
		logic signed [clc_pkg::DATA_W-1:0] front;
		logic signed [clc_pkg::DATA_W-1:0] back;
		logic [1:0]                        status;
	} list_view_t;

	// shadow of the node pool
	logic signed [clc_pkg::DATA_W-1:0] elem_mem    [clc_pkg::POOL_NODES];
	logic [clc_pkg::NODE_W-1:0]        next_mem    [clc_pkg::POOL_NODES];
	logic [clc_pkg::NODE_W-1:0]        spare_nodes [clc_pkg::POOL_NODES];
	logic [clc_pkg::NODE_W-1:0]        cursor;
	logic                              nonempty;
	logic [clc_pkg::CNT_W-1:0]         fresh_count;
	logic [clc_pkg::CNT_W-1:0]         spare_depth;

	list_view_t view_queue [$];
	list_view_t seen;
	list_view_t want;

	initial begin
		mismatch_count = 0;
		results_owed   = 0;
	end

	task automatic flag_mismatch(input string msg);
		$display("%0t ns: mismatch: %s", $realtime, msg);
		mismatch_count++;
	endtask

	// apply one request to the shadow list and return the view after it
	function automatic list_view_t apply_request(input logic [1:0] act,
			input logic signed [clc_pkg::DATA_W-1:0] val);
		list_view_t                 v;
		logic [clc_pkg::NODE_W-1:0] node;
		logic [clc_pkg::NODE_W-1:0] gone;
		logic                       got;
		v        = '0;
		v.status = clc_pkg::STS_DONE;
		node     = '0;
		got      = 1'b0;
		case (act)
			clc_pkg::ACT_ADD: begin
				// recycled nodes first, then never used ones
				if (spare_depth != 0) begin
					spare_depth = spare_depth - clc_pkg::CNT_W'(1);
					node        = spare_nodes[spare_depth[clc_pkg::NODE_W-1:0]];
					got         = 1'b1;
				end else if (fresh_count < clc_pkg::POOL_NODES) begin
					node        = fresh_count[clc_pkg::NODE_W-1:0];
					fresh_count = fresh_count + clc_pkg::CNT_W'(1);
					got         = 1'b1;
				end else begin
					v.status = clc_pkg::STS_FULL;
				end
				if (got) begin
					elem_mem[node] = val;
					if (!nonempty) begin
						next_mem[node] = node;
						cursor         = node;
						nonempty       = 1'b1;
					end else begin
						next_mem[node]   = next_mem[cursor];
						next_mem[cursor] = node;
					end
				end
			end
			clc_pkg::ACT_REMOVE: begin
				if (!nonempty) begin
					v.status = clc_pkg::STS_EMPTY;
				end else begin
					gone = next_mem[cursor];
					if (gone == cursor)
						nonempty = 1'b0;
					else
						next_mem[cursor] = next_mem[gone];
					if (spare_depth < clc_pkg::POOL_NODES) begin
						spare_nodes[spare_depth[clc_pkg::NODE_W-1:0]] = gone;
						spare_depth = spare_depth + clc_pkg::CNT_W'(1);
					end
				end
			end
			clc_pkg::ACT_ADVANCE: begin
				if (!nonempty)
					v.status = clc_pkg::STS_EMPTY;
				else
					cursor = next_mem[cursor];
			end
			default: ;
		endcase
		// front and back as seen from the cursor
		if (nonempty) begin
			v.is_empty = 1'b0;
			v.front    = elem_mem[next_mem[cursor]];
			v.back     = elem_mem[cursor];
		end else begin
			v.is_empty = 1'b1;
		end
		return v;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor       = '0;
			nonempty     = 1'b0;
			fresh_count  = '0;
			spare_depth  = '0;
			view_queue.delete();
			results_owed = 0;
		end else begin
			// compare a result against the oldest prediction
			if (done) begin
				seen = '{is_empty, front_value, back_value, status};
				if (view_queue.size() == 0) begin
					flag_mismatch($sformatf("result with no request waiting: %h", seen));
				end else begin
					want = view_queue.pop_front();
					if (seen.is_empty !== want.is_empty)
						flag_mismatch($sformatf("is_empty got %b expected %b",
							seen.is_empty, want.is_empty));
					if (seen.front !== want.front)
						flag_mismatch($sformatf("front_value got %h expected %h",
							seen.front, want.front));
					if (seen.back !== want.back)
						flag_mismatch($sformatf("back_value got %h expected %h",
							seen.back, want.back));
					if (seen.status !== want.status)
						flag_mismatch($sformatf("status got %0d expected %0d",
							seen.status, want.status));
				end
			end
			// predict for a request taken at this edge
			if (start && !busy)
				view_queue.push_back(apply_request(action, value));
			results_owed = view_queue.size();
		end
	end

endmodule

[bench/circular_list_with_cursor_core_tb.sv]
module circular_list_with_cursor_core_tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] ACT_NOP   = 2'd3;
	localparam int         MIX_FILL  = 0;
	localparam int         MIX_DRAIN = 1;
	localparam int         MIX_EVEN  = 2;
	localparam int         PHASE_REQUESTS = 608;
	localparam int         STALL_LIMIT    = 2000;

	logic               clk    = 1'b0;
	logic               arst_n = 1'b0;
	logic               start  = 1'b0;
	logic [1:0]         action = clc_pkg::ACT_ADD;
	logic signed [31:0] value  = '0;
	logic               busy;
	logic               done;
	logic               is_empty;
	logic signed [31:0] front_value;
	logic signed [31:0] back_value;
	logic [1:0]         status;

	int check_errors;
	int results_owed;
	int gap_pct;
	int stall_cycles = 0;
	int mix;
	int mix_left;

	always #5 clk = ~clk;

	circular_list_with_cursor_core uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.action      (action),
		.value       (value),
		.done        (done),
		.is_empty    (is_empty),
		.front_value (front_value),
		.back_value  (back_value),
		.status      (status)
	);

	clc_list_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.action         (action),
		.value          (value),
		.done           (done),
		.is_empty       (is_empty),
		.front_value    (front_value),
		.back_value     (back_value),
		.status         (status),
		.mismatch_count (check_errors),
		.results_owed   (results_owed)
	);

	// watchdog on cycles with no request taken and no result
	always @(posedge clk) begin
		if ((start && !busy) || done)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles == STALL_LIMIT) begin
			$display("circular_list_with_cursor_core_tb: done, errors");
			$finish;
		end
	end

	// one request, with a random gap before it
	task automatic issue(input logic [1:0] act, input logic signed [31:0] val);
		if ($urandom_range(0, 99) < gap_pct) begin
			start <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < gap_pct);
		end
		start  <= 1'b1;
		action <= act;
		value  <= val;
		@(negedge clk);
		while (busy) @(negedge clk);
		@(posedge clk);
	endtask

	// request mix leaning toward filling, draining, or neither
	function automatic logic [1:0] pick_action(input int lean);
		int roll;
		roll = $urandom_range(0, 99);
		case (lean)
			MIX_FILL:  return (roll < 70) ? clc_pkg::ACT_ADD :
				(roll < 85) ? clc_pkg::ACT_REMOVE :
				(roll < 95) ? clc_pkg::ACT_ADVANCE : ACT_NOP;
			MIX_DRAIN: return (roll < 15) ? clc_pkg::ACT_ADD :
				(roll < 80) ? clc_pkg::ACT_REMOVE :
				(roll < 95) ? clc_pkg::ACT_ADVANCE : ACT_NOP;
			default:   return (roll < 40) ? clc_pkg::ACT_ADD :
				(roll < 70) ? clc_pkg::ACT_REMOVE :
				(roll < 95) ? clc_pkg::ACT_ADVANCE : ACT_NOP;
		endcase
	endfunction

	// mostly random values, sometimes the extremes
	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(0, 15))
			0:       return 32'h8000_0000;
			1:       return 32'h7fff_ffff;
			2:       return 32'h0000_0000;
			3:       return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	initial begin
		gap_pct  = 22;
		mix_left = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// empty list: remove, advance and no-op
		issue(clc_pkg::ACT_REMOVE, 32'h0000_0000);
		issue(clc_pkg::ACT_ADVANCE, 32'hffff_ffff);
		issue(ACT_NOP, 32'h1234_5678);
		// single node, then removing it empties the list
		issue(clc_pkg::ACT_ADD, 32'h8000_0000);
		issue(clc_pkg::ACT_REMOVE, 32'h7fff_ffff);
		// reuse of a freed node, advance around a short ring
		issue(clc_pkg::ACT_ADD, 32'h7fff_ffff);
		issue(clc_pkg::ACT_ADD, 32'hffff_ffff);
		issue(clc_pkg::ACT_ADVANCE, 32'h0000_0000);
		issue(ACT_NOP, 32'h8000_0000);
		issue(clc_pkg::ACT_REMOVE, 32'h0000_0000);
		// fill the pool, then one add too many
		repeat (clc_pkg::POOL_NODES - 1) issue(clc_pkg::ACT_ADD, $urandom);
		issue(clc_pkg::ACT_ADD, 32'h5a5a_a5a5);

		// random phases with different sender gaps
		for (int phase = 0; phase < 3; phase++) begin
			gap_pct = (phase == 0) ? 22 : (phase == 1) ? 58 : 0;
			for (int n = 0; n < PHASE_REQUESTS; n++) begin
				if (mix_left == 0) begin
					mix      = $urandom_range(MIX_FILL, MIX_EVEN);
					mix_left = $urandom_range(20, 60);
				end
				mix_left--;
				issue(pick_action(mix), pick_value());
			end
		end
		start <= 1'b0;

		// drain outstanding results
		@(negedge clk);
		while (results_owed != 0) @(negedge clk);
		repeat (10) @(posedge clk);
		if (check_errors == 0)
			$display("circular_list_with_cursor_core_tb: done, clean");
		else
			$display("circular_list_with_cursor_core_tb: done, errors");
		$finish;
	end

endmodule
